/* rtl/core/voice_slot_allocator_top_defines.svh */
// Assertion macros used by the voice slot allocator engine.
// Needs a signal named clk and, for the gated form, a signal named rst in scope.
`ifndef VOICE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define VOICE_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Check that is switched off while reset is held
`define VSA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset
`define VSA_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/vsa_pkg.sv */
// Shared types and constants for the voice slot allocator.
// No dependencies.
package vsa_pkg;

  // Default number of voice slots
  localparam int VOICES_DEF = 16;

  // Request action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // How the slot was obtained
  typedef enum logic [1:0] {
    HOW_REUSE = 2'd0,
    HOW_EMPTY = 2'd1,
    HOW_STEAL = 2'd2,
    HOW_CLEAR = 2'd3
  } how_t;

  // Request payload
  typedef struct packed {
    logic        action;
    logic [31:0] now_pos;
    logic [31:0] start_pos;
    logic [15:0] length;
    logic [15:0] tone;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [3:0] slot;
    how_t       how;
  } res_t;

  // One stored voice entry
  typedef struct packed {
    logic [15:0] tone;
    logic [15:0] length;
    logic [31:0] start;
  } voice_word_t;

  // Engine sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_WRITE,
    ST_DONE
  } eng_state_t;

endpackage

/* rtl/core/voice_slot_allocator_top.sv */
// Top level of the voice slot allocator: request port, result register, engine.
// Depends on vsa_pkg and vsa_engine.

// An allocate request scans every slot of the voice memory once, one read a
// cycle, then writes the chosen slot and places the result in the output
// register; the single read port of the voice memory sets the pace of the
// scan. A clear request goes straight to its result. One request is worked
// on at a time; the next can be taken once the result has moved to the output
// register, even if that result still waits there.
module voice_slot_allocator_top #(
  parameter int VOICES = vsa_pkg::VOICES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  vsa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output vsa_pkg::res_t rsp
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic          res_valid;
  logic          res_take;
  vsa_pkg::res_t res;

  vsa_engine #(
    .VOICES (VOICES),
    .IW     (IW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register is free when empty or being drained
  assign res_take = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

endmodule

/* rtl/core/vsa_voice_mem.sv */
// Voice table memory: one write port, one read port, registered read data.
// Depends on vsa_pkg for the entry layout.
module vsa_voice_mem #(
  parameter int VOICES = vsa_pkg::VOICES_DEF,
  parameter int IW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  output vsa_pkg::voice_word_t  rd_data,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  vsa_pkg::voice_word_t  wr_data
);

  vsa_pkg::voice_word_t mem [VOICES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/vsa_engine.sv */
// Allocation engine: valid flags, slot scan over the voice memory, slot choice.
// Depends on vsa_pkg, vsa_voice_mem and the assertion macro header.
`include "voice_slot_allocator_top_defines.svh"

module vsa_engine #(
  parameter int VOICES = vsa_pkg::VOICES_DEF,
  parameter int IW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  vsa_pkg::req_t   req,
  output logic            res_valid,
  input  logic            res_take,
  output vsa_pkg::res_t   res
);

  localparam logic [IW-1:0] LAST_IDX = IW'(VOICES - 1);

  vsa_pkg::eng_state_t state, state_next;

  // Captured request
  logic [31:0] now_q;
  logic [31:0] start_q;
  logic [15:0] length_q;
  logic [15:0] tone_q;

  // Scan pipeline
  logic [IW-1:0]        cnt;
  logic                 s_vld;
  logic [IW-1:0]        s_idx;
  logic                 s_occ;
  vsa_pkg::voice_word_t rd_data;

  // Running choices
  logic          fin_found;
  logic [IW-1:0] fin_idx;
  logic          emp_found;
  logic [IW-1:0] emp_idx;
  logic [31:0]   old_start;
  logic [IW-1:0] old_idx;

  logic [VOICES-1:0]    valid_vec;
  logic                 accept;
  logic                 finished;
  logic [32:0]          end_sum;
  logic [IW-1:0]        pick_idx;
  vsa_pkg::how_t        pick_how;
  vsa_pkg::voice_word_t wr_word;

  assign accept = req_valid && req_ready;

  // Voice table storage
  vsa_voice_mem #(
    .VOICES (VOICES),
    .IW     (IW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (state == vsa_pkg::ST_READ),
    .rd_addr (cnt),
    .rd_data (rd_data),
    .wr_en   (state == vsa_pkg::ST_WRITE),
    .wr_addr (pick_idx),
    .wr_data (wr_word)
  );

  // Finished test at 33 bits so the end never wraps
  assign end_sum  = {1'b0, rd_data.start} + {17'b0, rd_data.length};
  assign finished = {1'b0, now_q} >= end_sum;

  // Slot choice in priority order
  always_comb begin
    if (fin_found) begin
      pick_idx = fin_idx;
      pick_how = vsa_pkg::HOW_REUSE;
    end else if (emp_found) begin
      pick_idx = emp_idx;
      pick_how = vsa_pkg::HOW_EMPTY;
    end else begin
      pick_idx = old_idx;
      pick_how = vsa_pkg::HOW_STEAL;
    end
  end

  assign wr_word = '{tone: tone_q, length: length_q, start: start_q};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake; no request is taken while reset is held
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      vsa_pkg::ST_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          state_next = (req.action == vsa_pkg::ACT_CLEAR) ? vsa_pkg::ST_DONE
                                                          : vsa_pkg::ST_READ;
        end
      end
      vsa_pkg::ST_READ: begin
        if (cnt == LAST_IDX) begin
          state_next = vsa_pkg::ST_LAST;
        end
      end
      vsa_pkg::ST_LAST:  state_next = vsa_pkg::ST_WRITE;
      vsa_pkg::ST_WRITE: state_next = vsa_pkg::ST_DONE;
      vsa_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = vsa_pkg::ST_IDLE;
        end
      end
      default: state_next = vsa_pkg::ST_IDLE;
    endcase
  end

  // Valid flags and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_vec <= '0;
      cnt       <= '0;
      s_vld     <= 1'b0;
    end else begin
      s_vld <= (state == vsa_pkg::ST_READ);
      if (accept) begin
        cnt <= '0;
        if (req.action == vsa_pkg::ACT_CLEAR) begin
          valid_vec <= '0;
        end
      end else if (state == vsa_pkg::ST_READ) begin
        cnt <= cnt + 1'b1;
      end
      if (state == vsa_pkg::ST_WRITE) begin
        valid_vec[pick_idx] <= 1'b1;
      end
    end
  end

  // Request capture, scan payload and running choices
  always_ff @(posedge clk) begin
    if (accept) begin
      now_q     <= req.now_pos;
      start_q   <= req.start_pos;
      length_q  <= req.length;
      tone_q    <= req.tone;
      fin_found <= 1'b0;
      emp_found <= 1'b0;
      res       <= '{slot: 4'd0, how: vsa_pkg::HOW_CLEAR};
    end
    s_idx <= cnt;
    s_occ <= valid_vec[cnt];
    if (s_vld) begin
      if (s_occ && finished && !fin_found) begin
        fin_found <= 1'b1;
        fin_idx   <= s_idx;
      end
      if (!s_occ && !emp_found) begin
        emp_found <= 1'b1;
        emp_idx   <= s_idx;
      end
      // Oldest start, strict compare keeps the lowest index on ties
      if (s_idx == '0 || rd_data.start < old_start) begin
        old_start <= rd_data.start;
        old_idx   <= s_idx;
      end
    end
    if (state == vsa_pkg::ST_WRITE) begin
      res <= '{slot: 4'(pick_idx), how: pick_how};
    end
  end

  `VSA_CHECK_ALWAYS(a_reset_idle, rst |=> state == vsa_pkg::ST_IDLE, "engine not idle after reset")
  `VSA_CHECK(a_clear_empties, (state == vsa_pkg::ST_DONE && res.how == vsa_pkg::HOW_CLEAR) |-> valid_vec == '0, "slots still valid after clear")
  `VSA_CHECK(a_steal_full, (state == vsa_pkg::ST_WRITE && !fin_found && !emp_found) |-> &valid_vec, "steal with an empty slot present")
  `VSA_CHECK(a_write_sets, state == vsa_pkg::ST_WRITE |=> valid_vec[$past(pick_idx)], "written slot not marked valid")

endmodule

/* sim/voice_slot_allocator_top_test.sv */
// Self-checking testbench for voice_slot_allocator_top: directed and random requests,
// each result checked against a local copy of the voice table.
// Depends on vsa_pkg and the RTL of voice_slot_allocator_top.
module voice_slot_allocator_top_test;
  import vsa_pkg::*;

  localparam int NV           = VOICES_DEF;
  localparam int IDLE_PCT     = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_REQS  = 700;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  res_t rsp;

  bit   steady      = 1'b0;
  int   errors      = 0;
  int   quiet_cycles = 0;
  res_t expected_q[$];

  // Local copy of the voice table
  logic        tbl_valid  [NV];
  logic [31:0] tbl_start  [NV];
  logic [15:0] tbl_length [NV];
  logic [15:0] tbl_tone   [NV];

  voice_slot_allocator_top #(.VOICES(NV)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the table copy and return the slot choice it causes
  function automatic res_t allocate_voice(req_t r);
    res_t        res;
    int          k;
    int          pick;
    how_t        how;
    bit          found;
    logic [32:0] voice_end;
    logic [31:0] oldest;
    found = 1'b0;
    pick  = 0;
    how   = HOW_REUSE;
    if (r.action == ACT_CLEAR) begin
      for (k = 0; k < NV; k++) tbl_valid[k] = 1'b0;
      res.slot = '0;
      res.how  = HOW_CLEAR;
      return res;
    end
    // lowest finished voice; end position kept at 33 bits
    for (k = 0; k < NV && !found; k++) begin
      voice_end = {1'b0, tbl_start[k]} + {17'd0, tbl_length[k]};
      if (tbl_valid[k] && {1'b0, r.now_pos} >= voice_end) begin
        pick  = k;
        how   = HOW_REUSE;
        found = 1'b1;
      end
    end
    // lowest empty slot
    for (k = 0; k < NV && !found; k++) begin
      if (!tbl_valid[k]) begin
        pick  = k;
        how   = HOW_EMPTY;
        found = 1'b1;
      end
    end
    // table full: oldest start wins, ties to the lowest index
    if (!found) begin
      oldest = tbl_start[0];
      pick   = 0;
      for (k = 1; k < NV; k++) begin
        if (tbl_start[k] < oldest) begin
          oldest = tbl_start[k];
          pick   = k;
        end
      end
      how = HOW_STEAL;
    end
    tbl_valid[pick]  = 1'b1;
    tbl_start[pick]  = r.start_pos;
    tbl_length[pick] = r.length;
    tbl_tone[pick]   = r.tone;
    res.slot = pick[3:0];
    res.how  = how;
    return res;
  endfunction

  function automatic req_t alloc_request(logic [31:0] now, logic [31:0] start,
                                         logic [15:0] len, logic [15:0] tone);
    req_t r;
    r.action    = ACT_ALLOC;
    r.now_pos   = now;
    r.start_pos = start;
    r.length    = len;
    r.tone      = tone;
    return r;
  endfunction

  function automatic req_t clear_request();
    req_t r;
    r           = '0;
    r.action    = ACT_CLEAR;
    r.now_pos   = $urandom();
    r.start_pos = $urandom();
    r.length    = 16'($urandom());
    r.tone      = 16'($urandom());
    return r;
  endfunction

  // Present one request, hold it until taken, then log its expected result
  task automatic send_request(input req_t r);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    expected_q = {expected_q, allocate_voice(r)};
  endtask

  // Result side: random back-pressure, off during the steady stretch
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: slot %0d how %0d", rsp.slot, rsp.how);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (rsp.slot !== want.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", want.slot, rsp.slot);
          errors++;
        end
        if (rsp.how !== want.how) begin
          $error("how mismatch: expected %0d, actual %0d", want.how, rsp.how);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Clear on an already empty table
  task automatic test_clear_empty_table();
    send_request(clear_request());
  endtask

  // Fill every slot with long voices at position 0, then steal twice;
  // slots 3 and 9 share the smallest start, so the tie goes to slot 3 first
  task automatic test_fill_then_steal();
    logic [31:0] st;
    for (int k = 0; k < NV; k++) begin
      if (k == 0)
        st = 32'hFFFF_FFFF;
      else if (k == 3 || k == 9)
        st = 32'd5;
      else
        st = 32'h1000_0000 + k;
      send_request(alloc_request(32'd0, st, 16'hFFFF, (k % 2) ? 16'hFFFF : 16'h0000));
    end
    send_request(alloc_request(32'd0, 32'hFFFF_FFF0, 16'hFFFF, 16'h5A5A));
    send_request(alloc_request(32'd0, 32'h8000_0000, 16'hFFFF, 16'hA5A5));
  endtask

  // End-position edges: no wrap of start + length, zero length finishing on
  // equality, and a voice one sample short of finished being stolen
  task automatic test_finish_boundaries();
    send_request(alloc_request(32'hFFFF_FFFF, 32'h0000_0100, 16'h0000, 16'h1234));
    send_request(alloc_request(32'h0000_0100, 32'h0000_0200, 16'h0001, 16'h4321));
    send_request(alloc_request(32'h0000_0200, 32'h0000_0000, 16'h0010, 16'h0F0F));
  endtask

  // Clear a full table, then the first allocate takes slot 0 as empty
  task automatic test_clear_full_table();
    send_request(clear_request());
    send_request(alloc_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0100, 16'h00FF));
  endtask

  // Mostly a running play position with voices of mixed length, some
  // clears, and some requests with every field random
  task automatic test_random_traffic();
    logic [31:0] play_pos;
    req_t        r;
    int          dice;
    int          span;
    play_pos = $urandom();
    for (int n = 0; n < RANDOM_REQS; n++) begin
      steady = (n >= 250 && n < 400);
      dice   = $urandom_range(99);
      if (dice < 3) begin
        r        = clear_request();
        play_pos = $urandom();
      end else if (dice < 8) begin
        r = alloc_request($urandom(), $urandom(), 16'($urandom()), 16'($urandom()));
      end else begin
        play_pos = play_pos + $urandom_range(40);
        span     = $urandom_range(2);
        r = alloc_request(play_pos, play_pos - 32'd4 + 32'($urandom_range(8)),
                          (span == 0) ? 16'($urandom_range(48)) :
                          (span == 1) ? 16'($urandom_range(600)) : 16'($urandom()),
                          16'($urandom()));
      end
      send_request(r);
    end
    steady = 1'b0;
  endtask

  initial begin
    foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_clear_empty_table();
    test_fill_then_steal();
    test_finish_boundaries();
    test_clear_full_table();
    test_random_traffic();

    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/vsa_pkg.sv
rtl/core/vsa_voice_mem.sv
rtl/core/vsa_engine.sv
rtl/core/voice_slot_allocator_top.sv
sim/voice_slot_allocator_top_test.sv
